[design/otls_pkg.sv]
// shared types and constants for the ordered tile list store
`default_nettype none

package otls_pkg;

    localparam int DEPTH       = 8;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int COUNT_OUT_W = 4;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 16;

    typedef enum logic [1:0] {
        OP_APPEND      = 2'd0,
        OP_REMOVE_LAST = 2'd1,
        OP_REMOVE_KEY  = 2'd2,
        OP_FIND        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] letter;
        logic [7:0] score;
    } t_entry;

    // result word, listed from the top bit down
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count_out;
        t_status                status;
        logic [7:0]             score_out;
        logic                   found;
    } t_result;

endpackage

`default_nettype wire

[design/ordered_tile_list_store_top.sv]
// Ordered tile list store: insertion-ordered list of letter/score entries
// held in a small memory and walked by one compare unit under a sequencer.
// One word is taken at a time. Append and remove-last pass from acceptance
// through the execute and done states to the result register. Find and
// remove-key read each entry through the registered memory read port, in a
// read state followed by a compare state, and stop at the first match or
// the list end; remove-key then moves each later entry down to close the
// gap, with a shift-read and a shift-write state per entry. The done state
// waits until the result register is free, and the block returns to idle
// before the next word is taken. The result sits in an output register, so
// the next word is accepted while a result still waits to be taken.
`default_nettype none

module ordered_tile_list_store_top
    import otls_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // op [1:0], tile_letter [9:2], tile_score [17:10], zero [23:18]
    input  wire  [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    // found [0], score_out [8:1], status [10:9], count_out [14:11], zero [15]
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    t_entry           r_mem [DEPTH];
    t_entry           r_rdata;

    t_state           r_state, n_state;
    t_op              r_op;
    logic [7:0]       r_key, r_score;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;
    logic [7:0]       r_score_out, n_score_out;
    t_status          r_status, n_status;
    logic             r_m_valid;
    t_result          r_m_data;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic             in_acc;
    logic             out_free;
    logic             is_match;
    logic             last_cmp;
    logic             last_shift;
    logic [CNT_W:0]   idx_p1;
    logic [CNT_W:0]   idx_p2;
    logic [CNT_W:0]   cnt_ext;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign is_match = (r_rdata.letter == r_key);
    assign idx_p1   = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign idx_p2   = {1'b0, r_idx} + (CNT_W+1)'(2);
    assign cnt_ext  = {1'b0, r_cnt};
    assign last_cmp   = (idx_p1 >= cnt_ext);
    assign last_shift = (idx_p2 >= cnt_ext);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_DATA_W-$bits(t_result)){1'b0}}, r_m_data};

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_APPEND, OP_REMOVE_LAST: n_state = S_DONE;
                    OP_REMOVE_KEY, OP_FIND: begin
                        n_state = (r_cnt == '0) ? S_DONE : S_RD;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                priority if (is_match) begin
                    if (r_op == OP_REMOVE_KEY && !last_cmp) begin
                        n_state = S_SH_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (last_cmp) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: n_state = last_shift ? S_DONE : S_SH_RD;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_found     = r_found;
        n_score_out = r_score_out;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt[IDX_W-1:0];
        mem_wdata   = '{letter: r_key, score: r_score};
        mem_raddr   = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_found     = 1'b0;
                n_score_out = '0;
                n_status    = ST_OK;
                n_idx       = '0;
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_APPEND: begin
                        if (r_cnt == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we = 1'b1;
                            n_cnt  = r_cnt + CNT_W'(1);
                        end
                    end
                    OP_REMOVE_LAST: begin
                        if (r_cnt == '0) n_status = ST_EMPTY;
                        else             n_cnt    = r_cnt - CNT_W'(1);
                    end
                    OP_REMOVE_KEY, OP_FIND: begin
                        if (r_cnt == '0) n_status = ST_EMPTY;
                    end
                    default: ;
                endcase
            end
            S_RD: ;
            S_CMP: begin
                priority if (is_match) begin
                    n_found = 1'b1;
                    if (r_op == OP_FIND) begin
                        n_score_out = r_rdata.score;
                    end else if (last_cmp) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end else if (last_cmp) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_SH_RD: begin
                mem_raddr = idx_p1[IDX_W-1:0];
            end
            S_SH_WR: begin
                // move the later entry down one place
                mem_we    = 1'b1;
                mem_waddr = r_idx[IDX_W-1:0];
                mem_wdata = r_rdata;
                n_idx     = r_idx + CNT_W'(1);
                if (last_shift) n_cnt = r_cnt - CNT_W'(1);
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_score_out <= n_score_out;
        r_status    <= n_status;
        if (in_acc) begin
            r_op    <= t_op'(i_s_axis_tdata[1:0]);
            r_key   <= i_s_axis_tdata[9:2];
            r_score <= i_s_axis_tdata[17:10];
        end
        if (r_state == S_DONE && out_free) begin
            r_m_data <= '{count_out: COUNT_OUT_W'(r_cnt), status: r_status,
                          score_out: r_score_out, found: r_found};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_SH_WR) |-> (r_idx < r_cnt))
        else $error("walk index past list end");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data.found) |-> (r_m_data.status == ST_OK))
        else $error("found flag with error status");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data.status == ST_EMPTY) |-> (r_m_data.count_out == '0))
        else $error("empty status with entries present");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

endmodule

`default_nettype wire
